// ===== sv/bplc_pkg.sv =====
// ----------------------------------------------------------------------------
// bplc_pkg: shared types and constants for the button press length classifier
// Holds the event codes, the register indexes, the threshold bundle and the
// word widths used by the top level and the per-button cells.
// ----------------------------------------------------------------------------
package bplc_pkg;

    // Number of buttons sampled per word: mode, start, user.
    localparam int BUTTON_COUNT = 3;

    // Default width of the per-button hold counter.
    localparam int COUNT_BITS_DEFAULT = 16;

    // Width of the threshold registers.
    localparam int THRESH_BITS = 16;

    // Configuration port widths.
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = THRESH_BITS;

    // Stream word widths, padded to whole bytes.
    localparam int IN_TDATA_BITS  = 8;
    localparam int OUT_TDATA_BITS = 8;

    // Threshold reset values.
    localparam logic [THRESH_BITS-1:0] MIN_PRESS_RESET  = 16'd2;
    localparam logic [THRESH_BITS-1:0] LONG_PRESS_RESET = 16'd250;

    // Register indexes.
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_MIN_PRESS  = 1'b0,
        REG_LONG_PRESS = 1'b1
    } cfg_reg_t;

    // Per-button press event.
    typedef enum logic [1:0] {
        BTN_EVENT_NONE  = 2'd0,
        BTN_EVENT_SHORT = 2'd1,
        BTN_EVENT_LONG  = 2'd2
    } btn_event_t;

    // Threshold bundle handed to every button cell.
    typedef struct packed {
        logic [THRESH_BITS-1:0] min_press_ticks;
        logic [THRESH_BITS-1:0] long_press_ticks;
    } bplc_thresh_t;

endpackage

// ===== sv/bplc_button.sv =====
// ----------------------------------------------------------------------------
// bplc_button: hold counter and release classifier for one button
// Keeps a saturating count of samples since the press and, on the sample
// that releases the button, grades the hold as none, short or long.
// ----------------------------------------------------------------------------
module bplc_button
    import bplc_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEFAULT
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         advance,   // sample moves on; commit the count
    input  logic         was,       // level on the previous sample
    input  logic         is_now,    // level on this sample
    input  bplc_thresh_t thresh,
    output btn_event_t   btn_event
);

    // Compare width covers both the counter and the thresholds.
    localparam int CMP_BITS = (COUNT_BITS > THRESH_BITS) ? COUNT_BITS : THRESH_BITS;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    logic [COUNT_BITS-1:0] hold_ticks_reg;
    logic [COUNT_BITS-1:0] hold_ticks_next;
    logic [COUNT_BITS-1:0] hold_inc;
    logic [CMP_BITS-1:0]   len_ext;
    logic [CMP_BITS-1:0]   min_ext;
    logic [CMP_BITS-1:0]   long_ext;

    // Count up while held, stopping at the top value.
    always_comb
    begin
        if (was && (hold_ticks_reg != COUNT_MAX))
        begin
            hold_inc = hold_ticks_reg + 1'b1;
        end
        else
        begin
            hold_inc = hold_ticks_reg;
        end
    end

    // A fresh press restarts the count.
    always_comb
    begin
        if (is_now && !was)
        begin
            hold_ticks_next = '0;
        end
        else
        begin
            hold_ticks_next = hold_inc;
        end
    end

    assign len_ext  = CMP_BITS'(hold_inc);
    assign min_ext  = CMP_BITS'(thresh.min_press_ticks);
    assign long_ext = CMP_BITS'(thresh.long_press_ticks);

    // Grade the hold on release; the glitch test goes first.
    always_comb
    begin
        btn_event = BTN_EVENT_NONE;
        if (was && !is_now)
        begin
            if (len_ext < min_ext)
            begin
                btn_event = BTN_EVENT_NONE;
            end
            else if (len_ext < long_ext)
            begin
                btn_event = BTN_EVENT_SHORT;
            end
            else
            begin
                btn_event = BTN_EVENT_LONG;
            end
        end
    end

    // Hold counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_ticks_reg <= '0;
        end
        else if (advance)
        begin
            hold_ticks_reg <= hold_ticks_next;
        end
    end

endmodule

// ===== sv/button_press_length_classifier.sv =====
// ----------------------------------------------------------------------------
// button_press_length_classifier: short and long press detector
// Samples three button levels per word and reports, for each button, a
// short or long press on the word that releases it.
// ----------------------------------------------------------------------------
//
//  channel   direction  fields (lowest bit up)
//  s_*       in         tdata: button_bits[2:0], zero pad [7:3]
//  m_*       out        tdata: mode_event[1:0], start_event[3:2],
//                              user_event[5:4], zero pad [7:6]
//  cfg_*     in         index 0 min_press_ticks, index 1 long_press_ticks
//
//  One word is accepted per cycle while s_tready is high; its result is
//  valid on m_* once it has passed the input and result registers.
//  Button state is committed as a word moves from the input register to
//  the result register, so one result per accepted word, in order.
//  A stalled result holds; one more input word is still taken into the
//  input register while the result waits.
//  Reset clears levels, counters and valids and loads the default thresholds.
//
module button_press_length_classifier
    import bplc_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEFAULT
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    // button_bits[2:0], pad [7:3]
    input  logic [IN_TDATA_BITS-1:0]  s_tdata,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // mode_event[1:0], start_event[3:2], user_event[5:4], pad [7:6]
    output logic [OUT_TDATA_BITS-1:0] m_tdata,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    bplc_thresh_t            thresh_reg;
    logic                    in_valid_reg;
    logic [BUTTON_COUNT-1:0] in_bits_reg;
    logic [BUTTON_COUNT-1:0] last_pressed_reg;
    logic                    out_valid_reg;
    btn_event_t              out_event_reg [BUTTON_COUNT];
    btn_event_t              btn_event     [BUTTON_COUNT];
    logic                    advance;

    // The input word moves on whenever the result register is free.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Threshold registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg.min_press_ticks  <= MIN_PRESS_RESET;
            thresh_reg.long_press_ticks <= LONG_PRESS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_MIN_PRESS:  thresh_reg.min_press_ticks  <= cfg_data;
                REG_LONG_PRESS: thresh_reg.long_press_ticks <= cfg_data;
                default:        thresh_reg <= thresh_reg;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_bits_reg <= s_tdata[BUTTON_COUNT-1:0];
        end
    end

    // Previous levels, committed with the word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_pressed_reg <= '0;
        end
        else if (advance)
        begin
            last_pressed_reg <= in_bits_reg;
        end
    end

    // One counter and classifier per button.
    for (genvar b = 0; b < BUTTON_COUNT; b++)
    begin : g_button
        bplc_button #(
            .COUNT_BITS (COUNT_BITS)
        ) u_button (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .was       (last_pressed_reg[b]),
            .is_now    (in_bits_reg[b]),
            .thresh    (thresh_reg),
            .btn_event (btn_event[b])
        );
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_event_reg <= btn_event;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_event_reg[2], out_event_reg[1], out_event_reg[0]};

endmodule

// ===== sv/bplc_checker.sv =====
// ----------------------------------------------------------------------------
// bplc_checker: port-level checks for the button press length classifier
// Watches the stream ports and flags stalled results that change, illegal
// event codes, dirty pad bits and a blocked input with an empty output.
// ----------------------------------------------------------------------------
module bplc_checker
    import bplc_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      s_tready,
    input logic [OUT_TDATA_BITS-1:0] m_tdata,
    input logic                      m_tvalid,
    input logic                      m_tready
);

    // A stalled result word holds its valid and its data.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result word changed");

    // No event field ever carries the unused code.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tdata[1:0] != 2'd3) && (m_tdata[3:2] != 2'd3)
                      && (m_tdata[5:4] != 2'd3)))
        else $error("event field holds an unused code");

    // Pad bits of the result word stay zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[7:6] == 2'b00))
        else $error("result pad bits set");

    // With the result register empty the input side never stalls.
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled while result register empty");

endmodule

bind button_press_length_classifier bplc_checker u_bplc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
